[hdl/ocl_pkg.sv]
// Shared types and constants for the ordered card list unit.
// Used by the controller, datapath, top level and checker; no dependencies.
package ocl_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CARD_W   = 6;

  // Request codes; codes above REQ_FIND are unknown requests.
  typedef enum logic [2:0] {
    REQ_PUSH         = 3'd0,
    REQ_POP          = 3'd1,
    REQ_REMOVE_AT    = 3'd2,
    REQ_REMOVE_MATCH = 3'd3,
    REQ_FIND         = 3'd4
  } req_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic ld_req;      // latch request fields, clear result staging
    logic wr_push;     // write key at the tail
    logic cnt_inc;
    logic cnt_dec;
    logic rd_top;      // read the last entry
    logic rd_ptr;      // read at the walk pointer while below the count
    logic wr_shift;    // write read data one entry down
    logic ptr_ld_zero;
    logic ptr_ld_pos;  // pointer = position + 1
    logic ptr_ld_hit;  // pointer = matching entry + 1
    logic set_miss;
    logic set_full;
    logic set_found;
    logic cap_pop;
    logic out_load;
  } ocl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] req;
    logic       full;
    logic       empty;
    logic       pos_bad;
    logic       hit;
    logic       walk_end;
  } ocl_sts_t;

endpackage

[hdl/ocl_datapath.sv]
// Datapath of the ordered card list: card store, count, walk pointer, result regs.
// Depends on ocl_pkg; driven by ocl_ctrl through ocl_cmd_t.
module ocl_datapath
  import ocl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        req_type_i,
  input  logic [1:0]        card_suit_i,
  input  logic [3:0]        card_value_i,
  input  logic [5:0]        position_in_i,
  input  ocl_cmd_t          cmd_i,
  output ocl_sts_t          sts_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  count_after_o,
  output logic [1:0]        out_suit_o,
  output logic [3:0]        out_value_o,
  output logic              found_o,
  output logic [ADDR_W-1:0] found_position_o
);

  logic [CARD_W-1:0] mem [CAPACITY];

  logic [2:0]        req_q;
  logic [CARD_W-1:0] key_q;
  logic [5:0]        pos_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  ptr_q;
  logic              rd_vld_q;
  logic [ADDR_W-1:0] rd_idx_q;
  logic [CARD_W-1:0] rdata_q;

  logic [1:0]        res_status_q;
  logic [CARD_W-1:0] res_card_q;
  logic              res_found_q;
  logic [ADDR_W-1:0] res_pos_q;

  logic [1:0]        out_status_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [CARD_W-1:0] out_card_q;
  logic              out_found_q;
  logic [ADDR_W-1:0] out_pos_q;

  logic              ptr_lt_cnt;
  logic [CNT_W-1:0]  cnt_m1;
  logic              rd_issue;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CARD_W-1:0] wr_data;

  assign ptr_lt_cnt = ptr_q < count_q;
  assign cnt_m1     = count_q - CNT_W'(1);
  assign rd_issue   = cmd_i.rd_top | (cmd_i.rd_ptr & ptr_lt_cnt);
  assign rd_addr    = cmd_i.rd_top ? cnt_m1[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];
  assign wr_en      = cmd_i.wr_push | (cmd_i.wr_shift & rd_vld_q);
  assign wr_addr    = cmd_i.wr_push ? count_q[ADDR_W-1:0] : rd_idx_q - ADDR_W'(1);
  assign wr_data    = cmd_i.wr_push ? key_q : rdata_q;

  // Store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rdata_q  <= mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ptr_ld_zero) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_ld_pos) begin
      ptr_q <= CNT_W'(pos_q) + CNT_W'(1);
    end else if (cmd_i.ptr_ld_hit) begin
      ptr_q <= CNT_W'(rd_idx_q) + CNT_W'(1);
    end else if (cmd_i.rd_ptr && ptr_lt_cnt) begin
      ptr_q <= ptr_q + CNT_W'(1);
    end
  end

  // Request fields and result staging.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_q        <= req_type_i;
      key_q        <= {card_suit_i, card_value_i};
      pos_q        <= position_in_i;
      res_status_q <= ST_OK;
      res_card_q   <= '0;
      res_found_q  <= 1'b0;
      res_pos_q    <= '0;
    end else begin
      if (cmd_i.set_miss) begin
        res_status_q <= ST_MISS;
      end else if (cmd_i.set_full) begin
        res_status_q <= ST_FULL;
      end
      if (cmd_i.set_found) begin
        res_found_q <= 1'b1;
        res_pos_q   <= rd_idx_q;
      end
      if (cmd_i.cap_pop) begin
        res_card_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
      out_card_q   <= res_card_q;
      out_found_q  <= res_found_q;
      out_pos_q    <= res_pos_q;
    end
  end

  assign sts_o.req      = req_q;
  assign sts_o.full     = count_q >= CNT_W'(CAPACITY);
  assign sts_o.empty    = count_q == '0;
  assign sts_o.pos_bad  = CNT_W'(pos_q) >= count_q;
  assign sts_o.hit      = rd_vld_q && (rdata_q == key_q);
  assign sts_o.walk_end = !rd_vld_q && !ptr_lt_cnt;

  assign status_o         = out_status_q;
  assign count_after_o    = out_count_q;
  assign out_suit_o       = out_card_q[5:4];
  assign out_value_o      = out_card_q[3:0];
  assign found_o          = out_found_q;
  assign found_position_o = out_pos_q;

endmodule

[hdl/ocl_ctrl.sv]
// Controller of the ordered card list: request sequencing and output handshake.
// Depends on ocl_pkg; commands ocl_datapath through ocl_cmd_t.
module ocl_ctrl
  import ocl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  ocl_sts_t sts_i,
  output ocl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (sts_i.req)
          REQ_PUSH: begin
            if (sts_i.full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.wr_push = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          REQ_POP: begin
            if (sts_i.empty) begin
              cmd_o.set_miss = 1'b1;
            end else begin
              cmd_o.rd_top  = 1'b1;
              cmd_o.cnt_dec = 1'b1;
              state_d       = S_POP_RD;
            end
          end
          REQ_REMOVE_AT: begin
            if (sts_i.pos_bad) begin
              cmd_o.set_miss = 1'b1;
            end else begin
              cmd_o.ptr_ld_pos = 1'b1;
              state_d          = S_SHIFT;
            end
          end
          REQ_REMOVE_MATCH, REQ_FIND: begin
            cmd_o.ptr_ld_zero = 1'b1;
            state_d           = S_SCAN;
          end
          default: begin
            cmd_o.set_miss = 1'b1;
          end
        endcase
      end
      S_POP_RD: begin
        cmd_o.cap_pop = 1'b1;
        state_d       = S_DONE;
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.set_found = 1'b1;
          if (sts_i.req == REQ_REMOVE_MATCH) begin
            cmd_o.ptr_ld_hit = 1'b1;
            state_d          = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end else if (sts_i.walk_end) begin
          cmd_o.set_miss = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.rd_ptr = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_shift = 1'b1;
        if (sts_i.walk_end) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_ptr = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

[hdl/ordered_card_list_unit.sv]
// Ordered card list: one request at a time. Push and bad requests finish without a
// walk, pop reads only the last entry, and remove-at, find and remove-match walk the
// store at one entry per cycle (single read port). The next request is taken the
// cycle after the result is loaded into the output register, even while it waits.
// Reset clears the count and handshake state; the store contents stay undefined.
module ordered_card_list_unit
  import ocl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        req_type_i,
  input  logic [1:0]        card_suit_i,
  input  logic [3:0]        card_value_i,
  input  logic [5:0]        position_in_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  count_after_o,
  output logic [1:0]        out_suit_o,
  output logic [3:0]        out_value_o,
  output logic              found_o,
  output logic [ADDR_W-1:0] found_position_o
);

  // Command and status between sequencer and datapath.
  ocl_cmd_t cmd;
  ocl_sts_t sts;

  // Sequencer: decode, store walk (search / compaction), output transfer.
  ocl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: store (1W/1R, registered read), count, pointer, result registers.
  // Compaction overlaps the read of entry j with the write of entry j-1's data into
  // j-2, i.e. read data from entry j is written to entry j-1 in the next cycle.
  ocl_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_type_i),
    .card_suit_i      (card_suit_i),
    .card_value_i     (card_value_i),
    .position_in_i    (position_in_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .count_after_o    (count_after_o),
    .out_suit_o       (out_suit_o),
    .out_value_o      (out_value_o),
    .found_o          (found_o),
    .found_position_o (found_position_o)
  );

endmodule

[hdl/ocl_checker.sv]
// Port-level checker for the ordered card list unit, bound to the top level.
// Depends on ocl_pkg.
module ocl_port_checks
  import ocl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [1:0]        status_o,
  input  logic [CNT_W-1:0]  count_after_o,
  input  logic              found_o,
  input  logic [ADDR_W-1:0] found_position_o
);

  // One request at a time: a request transfer closes the input until it is done.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in progress");

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Status code and count stay in range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3) && (count_after_o <= CNT_W'(CAPACITY)))
    else $error("status or count out of range");

  // Full is only reported with a full store.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> count_after_o == CNT_W'(CAPACITY))
    else $error("full reported below capacity");

  // A match is always a success and its position does not exceed the count after it.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |->
      (status_o == ST_OK) && (CNT_W'(found_position_o) <= count_after_o))
    else $error("inconsistent match report");

endmodule

bind ordered_card_list_unit ocl_port_checks u_ocl_port_checks (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .count_after_o    (count_after_o),
  .found_o          (found_o),
  .found_position_o (found_position_o)
);
